// ===== hw/rtl/two_axis_turret_limit_tracker_top_assert.svh =====
// assertion macros for the turret tracker rtl
`ifndef TWO_AXIS_TURRET_LIMIT_TRACKER_TOP_ASSERT_SVH
`define TWO_AXIS_TURRET_LIMIT_TRACKER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("turret tracker check failed");

// next-cycle implication, checked outside reset
`define TT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("turret tracker check failed");

`endif

// ===== hw/rtl/tturret_pkg.sv =====
// shared types, constants and helpers of the turret tracker
package tturret_pkg;

    localparam int unsigned TIME_DIVISOR_DEF = 1000000;
    localparam int unsigned DT_W      = 20;
    localparam int unsigned POS_W     = 32;
    localparam int unsigned MAG_W     = 31;
    localparam int unsigned PROD_W    = POS_W + DT_W;
    localparam int unsigned FIFO_DEPTH = 2;

    // direction codes
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_POS  = 2'd1;
    localparam logic [1:0] DIR_NEG  = 2'd2;

    // register indexes
    localparam logic [2:0] CFG_PAN_ACCEL  = 3'd0;
    localparam logic [2:0] CFG_PAN_LIMIT  = 3'd1;
    localparam logic [2:0] CFG_PAN_LOW    = 3'd2;
    localparam logic [2:0] CFG_PAN_HIGH   = 3'd3;
    localparam logic [2:0] CFG_TILT_ACCEL = 3'd4;
    localparam logic [2:0] CFG_TILT_LIMIT = 3'd5;
    localparam logic [2:0] CFG_TILT_LOW   = 3'd6;
    localparam logic [2:0] CFG_TILT_HIGH  = 3'd7;

    // active-low status bit positions
    localparam int unsigned S1_ROCKET1 = 0;
    localparam int unsigned S1_ROCKET2 = 1;
    localparam int unsigned S1_ROCKET3 = 6;
    localparam int unsigned S1_RIGHT   = 4;
    localparam int unsigned S2_LEFT    = 5;
    localparam int unsigned S2_BOTTOM  = 6;
    localparam int unsigned S2_TOP     = 7;

    // motor command bit positions
    localparam int unsigned CMD_FIRE     = 4;
    localparam int unsigned CMD_PAN_NEG  = 3;
    localparam int unsigned CMD_PAN_POS  = 2;
    localparam int unsigned CMD_TILT_POS = 1;
    localparam int unsigned CMD_TILT_NEG = 0;

    typedef struct packed {
        logic [DT_W-1:0] elapsed_us;
        logic            link_ok;
        logic [7:0]      status_first;
        logic [7:0]      status_second;
        logic            request_valid;
        logic [1:0]      pan_request;
        logic [1:0]      tilt_request;
        logic            fire_request;
    } in_word_t;

    typedef struct packed {
        logic [4:0]              motor_command;
        logic                    command_sent;
        logic signed [POS_W-1:0] pan_position;
        logic signed [POS_W-1:0] tilt_position;
        logic                    pan_calibrated;
        logic                    tilt_calibrated;
        logic [3:0]              end_stops;
        logic [2:0]              rockets_present;
        logic                    online;
    } out_word_t;

    // classified tick between front and back
    typedef struct packed {
        logic [DT_W-1:0] dt;
        logic            link_ok;
        logic            req_valid;
        logic [1:0]      pan_req;
        logic [1:0]      tilt_req;
        logic            fire_req;
        logic            stop_top;
        logic            stop_bottom;
        logic            stop_left;
        logic            stop_right;
        logic [2:0]      rockets;
    } tick_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // code three means no direction
    function automatic logic [1:0] dir_decode(input logic [1:0] code);
        dir_decode = (code == 2'd3) ? DIR_NONE : code;
    endfunction

endpackage

// ===== hw/rtl/tturret_fifo.sv =====
// small word queue with registered storage
module tturret_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = tturret_pkg::FIFO_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_reg, wr_next, rd_reg, rd_next;
    logic [AW:0]      cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == (AW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_reg];

    // pointer and count update
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // storage write
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= din;
        end
    end

endmodule

// ===== hw/rtl/tturret_front.sv =====
// input word classification: direction codes, stops and rockets
module tturret_front (
    input  tturret_pkg::in_word_t in_word,
    output tturret_pkg::tick_t    tick
);
    always_comb
    begin
        tick.dt          = in_word.elapsed_us;
        tick.link_ok     = in_word.link_ok;
        tick.req_valid   = in_word.request_valid;
        tick.pan_req     = tturret_pkg::dir_decode(in_word.pan_request);
        tick.tilt_req    = tturret_pkg::dir_decode(in_word.tilt_request);
        tick.fire_req    = in_word.fire_request;
        tick.stop_right  = !in_word.status_first[tturret_pkg::S1_RIGHT];
        tick.stop_left   = !in_word.status_second[tturret_pkg::S2_LEFT];
        tick.stop_top    = !in_word.status_second[tturret_pkg::S2_TOP];
        tick.stop_bottom = !in_word.status_second[tturret_pkg::S2_BOTTOM];
        tick.rockets     = {!in_word.status_first[tturret_pkg::S1_ROCKET3],
                            !in_word.status_first[tturret_pkg::S1_ROCKET2],
                            !in_word.status_first[tturret_pkg::S1_ROCKET1]};
    end

endmodule

// ===== hw/rtl/tturret_div.sv =====
// constant divider by exact reciprocal multiply, one partial product per cycle
module tturret_div #(
    parameter int unsigned DIVISOR = tturret_pkg::TIME_DIVISOR_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [tturret_pkg::PROD_W-1:0] dividend,
    output logic [tturret_pkg::PROD_W-1:0] quotient,
    output tturret_pkg::div_stat_t         stat
);
    // quotient = (dividend * ceil(2^K / DIVISOR)) >> K, exact for any NW-bit dividend
    localparam int unsigned NW    = tturret_pkg::PROD_W;
    localparam int unsigned LW    = $clog2(DIVISOR);
    localparam int unsigned K     = NW + LW;
    localparam int unsigned KW    = K + 2;
    localparam int unsigned MR    = NW + 1;
    localparam int unsigned ML    = MR / 2;
    localparam int unsigned MH    = MR - ML;
    localparam int unsigned XL    = NW / 2;
    localparam int unsigned XH    = NW - XL;
    localparam int unsigned PPW   = XH + MH;
    localparam int unsigned AW    = NW + MR;
    localparam int unsigned PARTS = 4;
    localparam int unsigned CW    = $clog2(PARTS);
    localparam logic [KW-1:0] POW_K   = KW'(1) << K;
    localparam logic [KW-1:0] DIV_K   = KW'(DIVISOR);
    localparam logic [KW-1:0] RECIP_K = (POW_K + DIV_K - KW'(1)) / DIV_K;
    localparam logic [MR-1:0] RECIP   = RECIP_K[MR-1:0];

    logic [NW-1:0]  x_reg;
    logic [AW-1:0]  acc_reg, pp_sh;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg, done_reg;
    logic [XH-1:0]  xa;
    logic [MH-1:0]  mb;
    logic [PPW-1:0] pp;

    assign quotient  = NW'(acc_reg >> K);
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    // partial product: low/high half of dividend times low/high half of reciprocal
    always_comb
    begin
        xa    = cnt_reg[1] ? x_reg[NW-1:XL] : XH'(x_reg[XL-1:0]);
        mb    = cnt_reg[0] ? RECIP[MR-1:ML] : MH'(RECIP[ML-1:0]);
        pp    = PPW'(xa) * PPW'(mb);
        pp_sh = AW'(pp);
        if (cnt_reg[0])
        begin
            pp_sh = pp_sh << ML;
        end
        if (cnt_reg[1])
        begin
            pp_sh = pp_sh << XL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(PARTS-1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: accumulate the shifted partial products
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            x_reg   <= dividend;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + pp_sh;
        end
    end

endmodule

// ===== hw/rtl/tturret_back.sv =====
// motion update sequencer, link handling and result build
module tturret_back #(
    parameter int unsigned TIME_DIVISOR = tturret_pkg::TIME_DIVISOR_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [2:0]                    cfg_index,
    input  logic [tturret_pkg::POS_W-1:0] cfg_data,
    input  logic                          tick_empty,
    input  tturret_pkg::tick_t            tick_dout,
    output logic                          tick_pop,
    input  logic                          out_full,
    output logic                          out_push,
    output tturret_pkg::out_word_t        out_din
);
    `include "two_axis_turret_limit_tracker_top_assert.svh"

    localparam int unsigned PW = tturret_pkg::POS_W;
    localparam int unsigned MW = tturret_pkg::MAG_W;
    localparam int unsigned NW = tturret_pkg::PROD_W;
    localparam int unsigned WW = NW + 2;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MULV  = 4'd1;
    localparam logic [3:0] S_GOV   = 4'd2;
    localparam logic [3:0] S_WAITV = 4'd3;
    localparam logic [3:0] S_MULA  = 4'd4;
    localparam logic [3:0] S_GOA   = 4'd5;
    localparam logic [3:0] S_WAITA = 4'd6;
    localparam logic [3:0] S_UPD   = 4'd7;
    localparam logic [3:0] S_LINK  = 4'd8;

    // configuration registers
    logic [MW-1:0]        pan_accel_reg, pan_limit_reg, tilt_accel_reg, tilt_limit_reg;
    logic signed [PW-1:0] pan_low_reg, pan_high_reg, tilt_low_reg, tilt_high_reg;

    // control and tracked state
    logic [3:0]           state_reg, state_next;
    logic                 ax_reg, ax_next;
    logic [1:0]           pan_wanted_reg, pan_wanted_next, tilt_wanted_reg, tilt_wanted_next;
    logic                 fire_wanted_reg, fire_wanted_next;
    logic [1:0]           pan_moving_reg, pan_moving_next, tilt_moving_reg, tilt_moving_next;
    logic signed [PW-1:0] pan_speed_reg, pan_speed_next, tilt_speed_reg, tilt_speed_next;
    logic signed [PW-1:0] pan_est_reg, pan_est_next, tilt_est_reg, tilt_est_next;
    logic                 pan_cal_reg, pan_cal_next, tilt_cal_reg, tilt_cal_next;
    logic [3:0]           stops_reg, stops_next;
    logic [2:0]           rockets_reg, rockets_next;
    logic                 link_up_reg, link_up_next;

    // datapath registers
    tturret_pkg::tick_t   tick_reg;
    logic [NW-1:0]        prod_reg, dv_reg, da_reg;

    // divider
    logic                   div_start;
    logic [NW-1:0]          div_quo;
    tturret_pkg::div_stat_t div_stat;

    // axis arithmetic
    logic signed [PW-1:0] old_s, est_s, lo_s, hi_s, spd_new, pos_new;
    logic [1:0]           mv;
    logic [MW-1:0]        acc, lim;
    logic [PW-1:0]        old_mag;
    logic [NW-1:0]        mul_res;
    logic signed [WW-1:0] old_w, delta, ns, lim_w, dpos, psum, lo_w, hi_w;
    logic                 neg_a, zero_a;
    logic [4:0]           cmd;

    assign div_start = (state_reg == S_GOV) || (state_reg == S_GOA);

    tturret_div #(
        .DIVISOR (TIME_DIVISOR)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    // axis selection
    always_comb
    begin
        old_s = ax_reg ? tilt_speed_reg  : pan_speed_reg;
        est_s = ax_reg ? tilt_est_reg    : pan_est_reg;
        lo_s  = ax_reg ? tilt_low_reg    : pan_low_reg;
        hi_s  = ax_reg ? tilt_high_reg   : pan_high_reg;
        mv    = ax_reg ? tilt_moving_reg : pan_moving_reg;
        acc   = ax_reg ? tilt_accel_reg  : pan_accel_reg;
        lim   = ax_reg ? tilt_limit_reg  : pan_limit_reg;
    end

    // shared multiplier: speed magnitude or acceleration times elapsed time
    always_comb
    begin
        old_mag = old_s[PW-1] ? PW'(-old_s) : PW'(old_s);
        if (state_reg == S_MULV)
        begin
            mul_res = NW'(old_mag) * NW'(tick_reg.dt);
        end
        else
        begin
            mul_res = NW'(acc) * NW'(tick_reg.dt);
        end
    end

    // speed ramp with exact braking, position step, clamps
    always_comb
    begin
        old_w  = {{(WW-PW){old_s[PW-1]}}, old_s};
        neg_a  = ((mv != tturret_pkg::DIR_POS) && (old_s > 0)) || (mv == tturret_pkg::DIR_NEG);
        zero_a = (mv == tturret_pkg::DIR_NONE) && (old_s == 0);
        if (zero_a)
        begin
            delta = '0;
        end
        else if (neg_a)
        begin
            delta = -$signed({2'b00, da_reg});
        end
        else
        begin
            delta = $signed({2'b00, da_reg});
        end
        ns = old_w + delta;
        if ((mv == tturret_pkg::DIR_NONE) &&
            (((ns > 0) && (old_s < 0)) || ((ns < 0) && (old_s > 0))))
        begin
            ns = '0;
        end
        lim_w = $signed({{(WW-MW){1'b0}}, lim});
        if (ns < -lim_w)
        begin
            ns = -lim_w;
        end
        if (ns > lim_w)
        begin
            ns = lim_w;
        end
        spd_new = ns[PW-1:0];

        dpos = old_s[PW-1] ? -$signed({2'b00, dv_reg}) : $signed({2'b00, dv_reg});
        psum = {{(WW-PW){est_s[PW-1]}}, est_s} + dpos;
        lo_w = {{(WW-PW){lo_s[PW-1]}}, lo_s};
        hi_w = {{(WW-PW){hi_s[PW-1]}}, hi_s};
        if (psum < lo_w)
        begin
            psum = lo_w;
        end
        if (psum > hi_w)
        begin
            psum = hi_w;
        end
        pos_new = psum[PW-1:0];
    end

    // sequencer and state update
    always_comb
    begin
        state_next       = state_reg;
        ax_next          = ax_reg;
        pan_wanted_next  = pan_wanted_reg;
        tilt_wanted_next = tilt_wanted_reg;
        fire_wanted_next = fire_wanted_reg;
        pan_moving_next  = pan_moving_reg;
        tilt_moving_next = tilt_moving_reg;
        pan_speed_next   = pan_speed_reg;
        tilt_speed_next  = tilt_speed_reg;
        pan_est_next     = pan_est_reg;
        tilt_est_next    = tilt_est_reg;
        pan_cal_next     = pan_cal_reg;
        tilt_cal_next    = tilt_cal_reg;
        stops_next       = stops_reg;
        rockets_next     = rockets_reg;
        link_up_next     = link_up_reg;
        tick_pop         = 1'b0;
        out_push         = 1'b0;
        cmd              = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (!tick_empty)
                begin
                    tick_pop   = 1'b1;
                    ax_next    = 1'b0;
                    state_next = S_MULV;
                    if (tick_dout.req_valid)
                    begin
                        pan_wanted_next  = tick_dout.pan_req;
                        tilt_wanted_next = tick_dout.tilt_req;
                        fire_wanted_next = tick_dout.fire_req;
                    end
                end
            end
            S_MULV:  state_next = S_GOV;
            S_GOV:   state_next = S_WAITV;
            S_WAITV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_MULA;
                end
            end
            S_MULA:  state_next = S_GOA;
            S_GOA:   state_next = S_WAITA;
            S_WAITA:
            begin
                if (div_stat.done)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                if (ax_reg)
                begin
                    tilt_speed_next = spd_new;
                    tilt_est_next   = pos_new;
                    state_next      = S_LINK;
                end
                else
                begin
                    pan_speed_next = spd_new;
                    pan_est_next   = pos_new;
                    ax_next        = 1'b1;
                    state_next     = S_MULV;
                end
            end
            S_LINK:
            begin
                if (!out_full)
                begin
                    out_push   = 1'b1;
                    state_next = S_IDLE;
                    if (!tick_reg.link_ok)
                    begin
                        link_up_next = 1'b0;
                    end
                    else
                    begin
                        rockets_next = tick_reg.rockets;
                        stops_next   = {tick_reg.stop_top, tick_reg.stop_bottom,
                                        tick_reg.stop_left, tick_reg.stop_right};
                        // drop requests that drive into a stop
                        if ((pan_wanted_reg == tturret_pkg::DIR_POS && tick_reg.stop_right) ||
                            (pan_wanted_reg == tturret_pkg::DIR_NEG && tick_reg.stop_left))
                        begin
                            pan_wanted_next = tturret_pkg::DIR_NONE;
                        end
                        if ((tilt_wanted_reg == tturret_pkg::DIR_POS && tick_reg.stop_top) ||
                            (tilt_wanted_reg == tturret_pkg::DIR_NEG && tick_reg.stop_bottom))
                        begin
                            tilt_wanted_next = tturret_pkg::DIR_NONE;
                        end
                        cmd[tturret_pkg::CMD_PAN_POS]  = (pan_wanted_next == tturret_pkg::DIR_POS);
                        cmd[tturret_pkg::CMD_PAN_NEG]  = (pan_wanted_next == tturret_pkg::DIR_NEG);
                        cmd[tturret_pkg::CMD_TILT_POS] = (tilt_wanted_next == tturret_pkg::DIR_POS);
                        cmd[tturret_pkg::CMD_TILT_NEG] = (tilt_wanted_next == tturret_pkg::DIR_NEG);
                        cmd[tturret_pkg::CMD_FIRE]     = fire_wanted_reg;
                        pan_moving_next  = pan_wanted_next;
                        tilt_moving_next = tilt_wanted_next;
                        // stop hits calibrate, right over left and bottom over top
                        if (tick_reg.stop_left)
                        begin
                            pan_est_next = pan_low_reg;
                            pan_cal_next = 1'b1;
                        end
                        if (tick_reg.stop_right)
                        begin
                            pan_est_next = pan_high_reg;
                            pan_cal_next = 1'b1;
                        end
                        if (tick_reg.stop_top)
                        begin
                            tilt_est_next = tilt_high_reg;
                            tilt_cal_next = 1'b1;
                        end
                        if (tick_reg.stop_bottom)
                        begin
                            tilt_est_next = tilt_low_reg;
                            tilt_cal_next = 1'b1;
                        end
                        // coming online clears calibration
                        if (!link_up_reg)
                        begin
                            pan_cal_next  = 1'b0;
                            tilt_cal_next = 1'b0;
                            link_up_next  = 1'b1;
                        end
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase

        out_din.motor_command   = cmd;
        out_din.command_sent    = tick_reg.link_ok;
        out_din.pan_position    = pan_est_next;
        out_din.tilt_position   = tilt_est_next;
        out_din.pan_calibrated  = pan_cal_next;
        out_din.tilt_calibrated = tilt_cal_next;
        out_din.end_stops       = stops_next;
        out_din.rockets_present = rockets_next;
        out_din.online          = link_up_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            ax_reg          <= 1'b0;
            pan_wanted_reg  <= tturret_pkg::DIR_NONE;
            tilt_wanted_reg <= tturret_pkg::DIR_NONE;
            fire_wanted_reg <= 1'b0;
            pan_moving_reg  <= tturret_pkg::DIR_NONE;
            tilt_moving_reg <= tturret_pkg::DIR_NONE;
            pan_speed_reg   <= '0;
            tilt_speed_reg  <= '0;
            pan_est_reg     <= '0;
            tilt_est_reg    <= '0;
            pan_cal_reg     <= 1'b0;
            tilt_cal_reg    <= 1'b0;
            stops_reg       <= '0;
            rockets_reg     <= '0;
            link_up_reg     <= 1'b0;
            pan_accel_reg   <= '0;
            pan_limit_reg   <= '0;
            pan_low_reg     <= '0;
            pan_high_reg    <= '0;
            tilt_accel_reg  <= '0;
            tilt_limit_reg  <= '0;
            tilt_low_reg    <= '0;
            tilt_high_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            ax_reg          <= ax_next;
            pan_wanted_reg  <= pan_wanted_next;
            tilt_wanted_reg <= tilt_wanted_next;
            fire_wanted_reg <= fire_wanted_next;
            pan_moving_reg  <= pan_moving_next;
            tilt_moving_reg <= tilt_moving_next;
            pan_speed_reg   <= pan_speed_next;
            tilt_speed_reg  <= tilt_speed_next;
            pan_est_reg     <= pan_est_next;
            tilt_est_reg    <= tilt_est_next;
            pan_cal_reg     <= pan_cal_next;
            tilt_cal_reg    <= tilt_cal_next;
            stops_reg       <= stops_next;
            rockets_reg     <= rockets_next;
            link_up_reg     <= link_up_next;
            // configuration word write
            if (cfg_valid)
            begin
                case (cfg_index)
                    tturret_pkg::CFG_PAN_ACCEL:  pan_accel_reg  <= cfg_data[MW-1:0];
                    tturret_pkg::CFG_PAN_LIMIT:  pan_limit_reg  <= cfg_data[MW-1:0];
                    tturret_pkg::CFG_PAN_LOW:    pan_low_reg    <= cfg_data;
                    tturret_pkg::CFG_PAN_HIGH:   pan_high_reg   <= cfg_data;
                    tturret_pkg::CFG_TILT_ACCEL: tilt_accel_reg <= cfg_data[MW-1:0];
                    tturret_pkg::CFG_TILT_LIMIT: tilt_limit_reg <= cfg_data[MW-1:0];
                    tturret_pkg::CFG_TILT_LOW:   tilt_low_reg   <= cfg_data;
                    tturret_pkg::CFG_TILT_HIGH:  tilt_high_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (tick_pop)
        begin
            tick_reg <= tick_dout;
        end
        if ((state_reg == S_MULV) || (state_reg == S_MULA))
        begin
            prod_reg <= mul_res;
        end
        if ((state_reg == S_WAITV) && div_stat.done)
        begin
            dv_reg <= div_quo;
        end
        if ((state_reg == S_WAITA) && div_stat.done)
        begin
            da_reg <= div_quo;
        end
    end

    `TT_ASSERT_NOW(a_push_room, out_push, !out_full)
    `TT_ASSERT_NOW(a_div_idle_start, div_start, !div_stat.busy)
    `TT_ASSERT_NEXT(a_pop_starts, tick_pop, state_reg == S_MULV && ax_reg == 1'b0)

endmodule

// ===== hw/rtl/two_axis_turret_limit_tracker_top.sv =====
// Two-axis turret tracker: one result word per tick word, in order. The motion engine takes a
// tick, then for each axis runs two multiply-and-divide passes (multiply, divider start, four
// partial products of the constant reciprocal multiply, quotient take) and one update step,
// then emits the result word before it takes the next tick. A full result queue holds the
// engine in its emit step. Two tick words queue ahead of the engine and two result words
// behind it. Configuration words are taken at any time (ready stays high) but must only be
// written while the block is idle.
module two_axis_turret_limit_tracker_top #(
    parameter int unsigned TIME_DIVISOR = tturret_pkg::TIME_DIVISOR_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  tturret_pkg::in_word_t         in_word,
    output logic                          empty,
    input  logic                          pop,
    output tturret_pkg::out_word_t        out_word,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [2:0]                    cfg_index,
    input  logic [tturret_pkg::POS_W-1:0] cfg_data
);
    localparam int unsigned TW = $bits(tturret_pkg::tick_t);
    localparam int unsigned OW = $bits(tturret_pkg::out_word_t);

    tturret_pkg::tick_t     tick_in, tick_dout;
    tturret_pkg::out_word_t out_din;
    logic                   tick_empty, tick_pop, out_full, out_push;

    assign cfg_ready = 1'b1;

    // front: classify
    tturret_front u_front (
        .in_word (in_word),
        .tick    (tick_in)
    );

    // tick queue between front and engine
    tturret_fifo #(
        .WIDTH (TW),
        .DEPTH (tturret_pkg::FIFO_DEPTH)
    ) u_tick_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (tick_in),
        .full  (full),
        .pop   (tick_pop),
        .dout  (tick_dout),
        .empty (tick_empty)
    );

    // back: motion engine
    tturret_back #(
        .TIME_DIVISOR (TIME_DIVISOR)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .tick_empty (tick_empty),
        .tick_dout  (tick_dout),
        .tick_pop   (tick_pop),
        .out_full   (out_full),
        .out_push   (out_push),
        .out_din    (out_din)
    );

    // result queue
    tturret_fifo #(
        .WIDTH (OW),
        .DEPTH (tturret_pkg::FIFO_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .din   (out_din),
        .full  (out_full),
        .pop   (pop),
        .dout  (out_word),
        .empty (empty)
    );

endmodule
